### hdl/fixed_step_frame_timer_macros.svh
// Assertion macros for the fixed step frame timer checker.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef FIXED_STEP_FRAME_TIMER_MACROS_SVH
`define FIXED_STEP_FRAME_TIMER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FSFT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FSFT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/fsft_pkg.sv
// Shared types and constants of the fixed step frame timer.
// Used by the controller, the datapath, the divider and the top level.
package fsft_pkg;

  // Field and state widths.
  localparam int unsigned TS_W      = 64;
  localparam int unsigned FREQ_W    = 32;
  localparam int unsigned RAW_W     = 29;
  localparam int unsigned TICK_W    = 24;
  localparam int unsigned LEFT_W    = 25;
  localparam int unsigned CNT_W     = 32;
  localparam int unsigned DIV_W     = 64;
  localparam int unsigned DIV_CNT_W = 7;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned OUT_W     = TICK_W + TS_W + 2 * CNT_W;

  // Snap window is the tick rate divided by this.
  localparam int unsigned SNAP_DIV = 4000;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_FREQ    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_RAW = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET  = 2'd3;

  // Register reset values.
  localparam logic [FREQ_W-1:0] FREQ_RST    = 32'd10000000;
  localparam logic [RAW_W-1:0]  MAX_RAW_RST = 29'd1000000;
  localparam logic [TICK_W-1:0] TARGET_RST  = 24'd166666;
  localparam logic [TICK_W-1:0] TICK_MAX    = '1;

  // Input opcodes.
  localparam logic OP_TICK   = 1'b0;
  localparam logic OP_REBASE = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DELTA,
    ST_MUL,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_SNAP,
    ST_EMIT,
    ST_LEFT,
    ST_LEFT_WAIT,
    ST_FPS,
    ST_SEC_WAIT
  } ctrl_state_e;

  // Which operands the shared divider works on.
  typedef enum logic [1:0] {
    DIV_TICKS,
    DIV_LEFT,
    DIV_SEC
  } div_sel_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     take_tick;
    logic     take_rebase;
    logic     delta;
    logic     mul;
    logic     div_start;
    div_sel_e div_sel;
    logic     snap;
    logic     emit;
    logic     left_direct;
    logic     left_from_div;
    logic     fps_roll;
    logic     sec_from_div;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_done;
    logic step_ok;
    logic emit_last;
    logic out_free;
    logic left_ge;
    logic sec_roll;
  } dp_status_t;

endpackage

### hdl/fsft_div.sv
// Shared restoring divider: one quotient bit per cycle.
// Depends on fsft_pkg for widths.
module fsft_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [fsft_pkg::DIV_W-1:0]     dividend_i,
  input  logic [fsft_pkg::FREQ_W-1:0]    divisor_i,
  input  logic [fsft_pkg::DIV_CNT_W-1:0] iters_i,
  output logic                           done_o,
  output logic [fsft_pkg::DIV_W-1:0]     quo_o,
  output logic [fsft_pkg::FREQ_W-1:0]    rem_o
);
  import fsft_pkg::*;

  logic [DIV_W-1:0]     quo_q, quo_d;
  logic [FREQ_W-1:0]    rem_q, rem_d;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 busy_q, done_q;
  logic [DIV_CNT_W-1:0] shamt;
  logic [FREQ_W:0]      shifted, diff;
  logic                 ge;

  // The dividend is left aligned so that only its significant bits are iterated.
  assign shamt = DIV_CNT_W'(DIV_W) - iters_i;

  // One restoring step.
  always_comb begin
    shifted = {rem_q, quo_q[DIV_W-1]};
    diff    = shifted - {1'b0, divisor_i};
    ge      = (shifted >= {1'b0, divisor_i});
    rem_d   = ge ? diff[FREQ_W-1:0] : shifted[FREQ_W-1:0];
    quo_d   = {quo_q[DIV_W-2:0], ge};
  end

  // Control: iteration count and completion flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= iters_i;
      busy_q <= 1'b1;
      done_q <= 1'b0;
    end else if (busy_q) begin
      cnt_q <= cnt_q - DIV_CNT_W'(1);
      if (cnt_q == DIV_CNT_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  // Working registers.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i << shamt;
      rem_q <= '0;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

### hdl/fsft_dp.sv
// Datapath of the fixed step frame timer: configuration, timing state,
// tick conversion, output register. Depends on fsft_pkg and fsft_div.
module fsft_dp #(
  parameter int unsigned TICKS_PER_SECOND = 10000000,
  parameter int unsigned MAX_UPDATES      = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [fsft_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [fsft_pkg::FREQ_W-1:0]    cfg_wdata_i,
  input  logic [fsft_pkg::TS_W-1:0]      in_ts_i,
  input  fsft_pkg::dp_cmd_t              cmd_i,
  output fsft_pkg::dp_status_t           status_o,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [fsft_pkg::OUT_W-1:0]     out_data_o,
  output logic                           out_last_o
);
  import fsft_pkg::*;

  localparam int unsigned TPS_W  = $clog2(TICKS_PER_SECOND + 1);
  localparam int unsigned PROD_W = RAW_W + TPS_W;
  localparam int unsigned NW     = (MAX_UPDATES > 1) ? $clog2(MAX_UPDATES) : 1;
  localparam logic [NW-1:0]     N_LAST  = NW'(MAX_UPDATES - 1);
  localparam logic [TPS_W-1:0]  TPS_C   = TPS_W'(TICKS_PER_SECOND);
  localparam logic [TICK_W-1:0] SNAP_TH = TICK_W'(TICKS_PER_SECOND / SNAP_DIV);

  // Configuration registers.
  logic [FREQ_W-1:0] freq_q;
  logic [RAW_W-1:0]  max_raw_q;
  logic              fixed_q;
  logic [TICK_W-1:0] target_q;

  // Timing state.
  logic [TS_W-1:0]   ts_q, last_ts_q, sec_q, total_q;
  logic [RAW_W-1:0]  raw_q;
  logic [PROD_W-1:0] prod_q;
  logic [TICK_W-1:0] ticks_q;
  logic [LEFT_W-1:0] left_q, leftover_q;
  logic [CNT_W-1:0]  frame_q, frames_sec_q, fps_q;
  logic [NW-1:0]     n_q;

  // Output register.
  logic              out_valid_q, out_last_q;
  logic [OUT_W-1:0]  out_data_q;

  // Divider interface.
  logic [DIV_W-1:0]     div_dividend, div_quo;
  logic [FREQ_W-1:0]    div_divisor, div_rem;
  logic [DIV_CNT_W-1:0] div_iters;
  logic                 div_done;

  // Derived values.
  logic [FREQ_W-1:0] freq_eff;
  logic [TICK_W-1:0] target_eff;
  logic [LEFT_W-1:0] target_l, left_minus;
  logic [TS_W-1:0]   raw_full;
  logic [TICK_W-1:0] ticks_sat, tick_diff, snapped, step_val;
  logic [TS_W-1:0]   total_next;
  logic              out_free;

  // A zero frequency or target counts as one.
  assign freq_eff   = (freq_q == '0) ? FREQ_W'(1) : freq_q;
  assign target_eff = (target_q == '0) ? TICK_W'(1) : target_q;
  assign target_l   = LEFT_W'(target_eff);
  assign raw_full   = ts_q - last_ts_q;
  assign left_minus = left_q - target_l;
  assign out_free   = !out_valid_q || out_ready_i;

  // Saturate the converted delta, then snap it to the target when close.
  always_comb begin
    ticks_sat = (|div_quo[DIV_W-1:TICK_W]) ? TICK_MAX : div_quo[TICK_W-1:0];
    tick_diff = (ticks_sat >= target_eff) ? (ticks_sat - target_eff)
                                          : (target_eff - ticks_sat);
    snapped   = (tick_diff < SNAP_TH) ? target_eff : ticks_sat;
  end

  // Value reported by one update.
  assign step_val   = fixed_q ? target_eff : ticks_q;
  assign total_next = total_q + TS_W'(step_val);

  // Operand selection for the shared divider.
  always_comb begin
    unique case (cmd_i.div_sel)
      DIV_LEFT: begin
        div_dividend = DIV_W'(left_q);
        div_divisor  = FREQ_W'(target_eff);
        div_iters    = DIV_CNT_W'(LEFT_W);
      end
      DIV_SEC: begin
        div_dividend = sec_q;
        div_divisor  = freq_eff;
        div_iters    = DIV_CNT_W'(DIV_W);
      end
      default: begin
        div_dividend = DIV_W'(prod_q);
        div_divisor  = freq_eff;
        div_iters    = DIV_CNT_W'(PROD_W);
      end
    endcase
  end

  fsft_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .iters_i    (div_iters),
    .done_o     (div_done),
    .quo_o      (div_quo),
    .rem_o      (div_rem)
  );

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      freq_q    <= FREQ_RST;
      max_raw_q <= MAX_RAW_RST;
      fixed_q   <= 1'b0;
      target_q  <= TARGET_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FREQ:    freq_q    <= cfg_wdata_i;
        CFG_MAX_RAW: max_raw_q <= cfg_wdata_i[RAW_W-1:0];
        CFG_MODE:    fixed_q   <= cfg_wdata_i[0];
        CFG_TARGET:  target_q  <= cfg_wdata_i[TICK_W-1:0];
        default:     freq_q    <= freq_q;
      endcase
    end
  end

  // Architectural timing state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_ts_q    <= '0;
      sec_q        <= '0;
      leftover_q   <= '0;
      total_q      <= '0;
      frame_q      <= '0;
      frames_sec_q <= '0;
      fps_q        <= '0;
    end else begin
      if (cmd_i.take_rebase) begin
        last_ts_q <= in_ts_i;
      end else if (cmd_i.delta) begin
        last_ts_q <= ts_q;
      end

      if (cmd_i.take_rebase) begin
        sec_q <= '0;
      end else if (cmd_i.delta) begin
        sec_q <= sec_q + raw_full;
      end else if (cmd_i.sec_from_div) begin
        sec_q <= TS_W'(div_rem);
      end

      if (cmd_i.take_rebase) begin
        leftover_q <= '0;
      end else if (cmd_i.left_direct) begin
        leftover_q <= left_q;
      end else if (cmd_i.left_from_div) begin
        leftover_q <= LEFT_W'(div_rem);
      end

      if (cmd_i.emit) begin
        total_q <= total_next;
        frame_q <= frame_q + CNT_W'(1);
      end

      if (cmd_i.take_rebase || cmd_i.fps_roll) begin
        frames_sec_q <= '0;
      end else if (cmd_i.emit && status_o.emit_last) begin
        frames_sec_q <= frames_sec_q + CNT_W'(1);
      end

      if (cmd_i.take_rebase) begin
        fps_q <= '0;
      end else if (cmd_i.fps_roll) begin
        fps_q <= frames_sec_q;
      end
    end
  end

  // Per-item working registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.take_tick) begin
      ts_q <= in_ts_i;
    end
    if (cmd_i.delta) begin
      raw_q <= (raw_full > TS_W'(max_raw_q)) ? max_raw_q : raw_full[RAW_W-1:0];
    end
    if (cmd_i.mul) begin
      prod_q <= PROD_W'(raw_q) * PROD_W'(TPS_C);
    end
    if (cmd_i.snap) begin
      ticks_q <= ticks_sat;
      left_q  <= fixed_q ? (LEFT_W'(leftover_q) + LEFT_W'(snapped)) : '0;
      n_q     <= '0;
    end else if (cmd_i.emit && fixed_q) begin
      left_q <= left_minus;
      n_q    <= n_q + NW'(1);
    end
  end

  // Output register: loaded by an update, freed when the beat is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_data_q <= {fps_q, frame_q + CNT_W'(1), total_next, step_val};
      out_last_q <= status_o.emit_last;
    end
  end

  // Status toward the controller.
  always_comb begin
    status_o.div_done  = div_done;
    status_o.step_ok   = !fixed_q || (left_q >= target_l);
    status_o.emit_last = !fixed_q || (left_minus < target_l) || (n_q == N_LAST);
    status_o.out_free  = out_free;
    status_o.left_ge   = fixed_q && (left_q >= target_l);
    status_o.sec_roll  = (sec_q >= TS_W'(freq_eff));
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_last_o  = out_last_q;

endmodule

### hdl/fsft_ctrl.sv
// Controller state machine of the fixed step frame timer.
// Depends on fsft_pkg for the state, command and status types.
module fsft_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_opcode_i,
  output logic                 in_ready_o,
  input  fsft_pkg::dp_status_t status_i,
  output fsft_pkg::dp_cmd_t    cmd_o
);
  import fsft_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && (in_opcode_i == OP_TICK)) state_d = ST_DELTA;
      end
      ST_DELTA:  state_d = ST_MUL;
      ST_MUL:    state_d = ST_DIV_GO;
      ST_DIV_GO: state_d = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (status_i.div_done) state_d = ST_SNAP;
      end
      ST_SNAP: state_d = ST_EMIT;
      ST_EMIT: begin
        if (!status_i.step_ok) begin
          state_d = ST_LEFT;
        end else if (status_i.out_free && status_i.emit_last) begin
          state_d = ST_LEFT;
        end
      end
      ST_LEFT: state_d = status_i.left_ge ? ST_LEFT_WAIT : ST_FPS;
      ST_LEFT_WAIT: begin
        if (status_i.div_done) state_d = ST_FPS;
      end
      ST_FPS: state_d = status_i.sec_roll ? ST_SEC_WAIT : ST_IDLE;
      ST_SEC_WAIT: begin
        if (status_i.div_done) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Commands.
  always_comb begin
    cmd_o         = '0;
    cmd_o.div_sel = DIV_TICKS;
    in_ready_o    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o        = 1'b1;
        cmd_o.take_tick   = in_valid_i && (in_opcode_i == OP_TICK);
        cmd_o.take_rebase = in_valid_i && (in_opcode_i == OP_REBASE);
      end
      ST_DELTA: cmd_o.delta = 1'b1;
      ST_MUL:   cmd_o.mul = 1'b1;
      ST_DIV_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DIV_TICKS;
      end
      ST_DIV_WAIT: cmd_o.div_sel = DIV_TICKS;
      ST_SNAP:     cmd_o.snap = 1'b1;
      ST_EMIT:     cmd_o.emit = status_i.step_ok && status_i.out_free;
      ST_LEFT: begin
        cmd_o.div_sel = DIV_LEFT;
        if (status_i.left_ge) begin
          cmd_o.div_start = 1'b1;
        end else begin
          cmd_o.left_direct = 1'b1;
        end
      end
      ST_LEFT_WAIT: begin
        cmd_o.div_sel       = DIV_LEFT;
        cmd_o.left_from_div = status_i.div_done;
      end
      ST_FPS: begin
        cmd_o.div_sel   = DIV_SEC;
        cmd_o.fps_roll  = status_i.sec_roll;
        cmd_o.div_start = status_i.sec_roll;
      end
      ST_SEC_WAIT: begin
        cmd_o.div_sel      = DIV_SEC;
        cmd_o.sec_from_div = status_i.div_done;
      end
      default: cmd_o.div_sel = DIV_TICKS;
    endcase
  end

endmodule

### hdl/fixed_step_frame_timer.sv
// Fixed step frame timer, top level: controller plus datapath.
// Depends on fsft_pkg, fsft_ctrl, fsft_dp and fsft_div.
//
// Usage: send raw counter timestamps; tuser 0 is a tick, tuser 1 re-bases time.
// A re-base beat produces nothing. A tick beat passes through the clamp, the
// multiply, the bit-serial divide by the counter frequency and the bookkeeping
// around it, then produces its update beats, if any, one by one. Each update
// beat also waits while the output register still holds a beat that has not
// been taken. When fixed mode drops whole steps, the leftover is also reduced
// modulo the target, and when a raw-count second rolls over, the raw-count
// second is reduced modulo the frequency. All divisions share one restoring
// divider that retires one quotient bit per cycle, and that divider sets the
// rate. Update beats leave through an output register, so the next timestamp
// is taken while the last update of the previous one still waits.
module fixed_step_frame_timer #(
  parameter int unsigned TICKS_PER_SECOND = 10000000,
  parameter int unsigned MAX_UPDATES      = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Configuration write port.
  input  logic                           cfg_we_i,
  input  logic [fsft_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [fsft_pkg::FREQ_W-1:0]    cfg_wdata_i,
  // Timestamp stream.
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [fsft_pkg::TS_W-1:0]      s_axis_tdata,   // [63:0] timestamp
  input  logic                           s_axis_tuser,   // [0] opcode
  // Update stream.
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [23:0] step_ticks, [87:24] total_ticks, [119:88] frame_number,
  // [151:120] frames_per_second
  output logic [fsft_pkg::OUT_W-1:0]     m_axis_tdata,
  output logic                           m_axis_tlast
);
  import fsft_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  fsft_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_opcode_i (s_axis_tuser),
    .in_ready_o  (s_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  fsft_dp #(
    .TICKS_PER_SECOND (TICKS_PER_SECOND),
    .MAX_UPDATES      (MAX_UPDATES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_ts_i     (s_axis_tdata),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule

### hdl/fsft_checker.sv
// Port-level checks of the fixed step frame timer, bound to the top level.
// Depends on fsft_pkg and fixed_step_frame_timer_macros.svh.
`include "fixed_step_frame_timer_macros.svh"

module fsft_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           cfg_we_i,
  input logic [fsft_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input logic [fsft_pkg::FREQ_W-1:0]    cfg_wdata_i,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [fsft_pkg::OUT_W-1:0]     m_axis_tdata,
  input logic                           m_axis_tlast
);
  import fsft_pkg::*;

  logic              beat;
  logic              mode_q;
  logic [TICK_W-1:0] target_q, target_eff;
  logic [CNT_W-1:0]  prev_frame_q;
  logic [TS_W-1:0]   prev_total_q;

  assign beat       = m_axis_tvalid && m_axis_tready;
  assign target_eff = (target_q == '0) ? TICK_W'(1) : target_q;

  // Mirror of the mode registers and of the last delivered counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= 1'b0;
      target_q     <= TARGET_RST;
      prev_frame_q <= '0;
      prev_total_q <= '0;
    end else begin
      if (cfg_we_i && (cfg_idx_i == CFG_MODE)) begin
        mode_q <= cfg_wdata_i[0];
      end
      if (cfg_we_i && (cfg_idx_i == CFG_TARGET)) begin
        target_q <= cfg_wdata_i[TICK_W-1:0];
      end
      if (beat) begin
        prev_frame_q <= m_axis_tdata[119:88];
        prev_total_q <= m_axis_tdata[87:24];
      end
    end
  end

  // A stalled update beat keeps its contents.
  `FSFT_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "update beat changed while stalled")

  // Every update advances the frame number by exactly one.
  `FSFT_ASSERT_IMP(a_frame_seq, beat, m_axis_tdata[119:88] == prev_frame_q + 32'd1, "frame number skipped")

  // The running total grows by the step of each update.
  `FSFT_ASSERT_IMP(a_total_sum, beat, m_axis_tdata[87:24] == prev_total_q + 64'(m_axis_tdata[23:0]), "total ticks do not match steps")

  // In fixed mode every update is one whole target step.
  `FSFT_ASSERT_IMP(a_fixed_step, beat && mode_q, m_axis_tdata[23:0] == target_eff, "fixed mode step differs from target")

endmodule

bind fixed_step_frame_timer fsft_checker u_fsft_checker (.*);

### verif/fixed_step_frame_timer_tb.sv
// Self-checking testbench for the fixed step frame timer.
// Needs fsft_pkg and the fixed_step_frame_timer RTL; a behavioral predictor
// inside this file supplies the expected update beats.
`timescale 1ns / 1ps

module fixed_step_frame_timer_tb;
  import fsft_pkg::*;

  localparam int unsigned TICK_RATE       = 10000000;
  localparam int unsigned UPDATE_LIMIT    = 64;
  localparam int unsigned SNAP_WINDOW     = TICK_RATE / SNAP_DIV;
  localparam int unsigned SETTLE_CYCLES   = 400;
  localparam int unsigned CYCLE_LIMIT     = 4000000;
  localparam int unsigned RAND_PHASES     = 6;
  localparam int unsigned ITEMS_PER_PHASE = 52;
  localparam int unsigned PLAN_LEN        = 32;

  // One update beat as the block reports it.
  typedef struct packed {
    logic [TICK_W-1:0] step_ticks;
    logic [TS_W-1:0]   total_ticks;
    logic [CNT_W-1:0]  frame_number;
    logic [CNT_W-1:0]  frames_per_second;
    logic              last;
  } update_t;

  localparam update_t NO_WANT = '0;

  typedef enum logic [1:0] {
    ROW_CFG,
    ROW_TICK,
    ROW_REBASE
  } row_kind_e;

  // Directed stimulus row. Items either carry an absolute timestamp or a
  // delta from the previous one; typed rows carry the update written out.
  typedef struct {
    row_kind_e             kind;
    logic [CFG_IDX_W-1:0]  idx;
    bit                    rel;
    logic [TS_W-1:0]       value;
    bit                    typed;
    update_t               want;
  } plan_row_t;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_CHOPPY,
    RX_SPARSE,
    RX_BLOCKED
  } rx_mode_e;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i     = CFG_FREQ;
  logic [FREQ_W-1:0]    cfg_wdata_i   = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [TS_W-1:0]      s_axis_tdata  = '0;
  logic                 s_axis_tuser  = OP_TICK;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OUT_W-1:0]     m_axis_tdata;
  logic                 m_axis_tlast;

  fixed_step_frame_timer #(
    .TICKS_PER_SECOND(TICK_RATE),
    .MAX_UPDATES     (UPDATE_LIMIT)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),   // [63:0] timestamp
    .s_axis_tuser (s_axis_tuser),   // [0] opcode
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    // [23:0] step_ticks, [87:24] total_ticks, [119:88] frame_number,
    // [151:120] frames_per_second
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always #1 clk_i = ~clk_i;

  // Shadow copies of the configuration registers.
  logic [FREQ_W-1:0] freq_reg       = FREQ_RST;
  logic [RAW_W-1:0]  max_raw_reg    = MAX_RAW_RST;
  logic              fixed_mode_reg = 1'b0;
  logic [TICK_W-1:0] target_reg     = TARGET_RST;

  // Timer state as the predictor tracks it.
  logic [TS_W-1:0]   last_stamp       = '0;
  logic [TS_W-1:0]   raw_second       = '0;
  logic [LEFT_W-1:0] leftover         = '0;
  logic [TS_W-1:0]   total_acc        = '0;
  logic [CNT_W-1:0]  frame_cnt        = '0;
  logic [CNT_W-1:0]  frames_in_second = '0;
  logic [CNT_W-1:0]  fps_measured     = '0;

  update_t     pending_updates[$];
  int unsigned mismatch_count = 0;
  int unsigned burst_left     = 0;
  plan_row_t   plan[PLAN_LEN];

  // Works out the update beats that one timestamp beat causes.
  task automatic advance_timer(input logic op, input logic [TS_W-1:0] stamp,
                               output update_t outs[$]);
    logic [63:0]      freq_eff;
    logic [63:0]      raw;
    logic [63:0]      ticks;
    logic [63:0]      target;
    logic [63:0]      gap_to_target;
    logic [63:0]      left;
    logic [CNT_W-1:0] fps_seen;
    int               n;
    outs = {};
    n = 0;
    fps_seen = fps_measured;
    freq_eff = (freq_reg == '0) ? 64'd1 : 64'(freq_reg);
    if (op == OP_REBASE) begin
      last_stamp = stamp;
      leftover = '0;
      fps_measured = '0;
      frames_in_second = '0;
      raw_second = '0;
    end else begin
      raw = stamp - last_stamp;
      last_stamp = stamp;
      raw_second += raw;
      if (raw > 64'(max_raw_reg)) raw = 64'(max_raw_reg);
      ticks = raw * 64'(TICK_RATE) / freq_eff;
      if (ticks > 64'(TICK_MAX)) ticks = 64'(TICK_MAX);
      if (fixed_mode_reg) begin
        target = (target_reg == '0) ? 64'd1 : 64'(target_reg);
        gap_to_target = (ticks > target) ? ticks - target : target - ticks;
        // Frames close to the target length count as exactly one step.
        if (gap_to_target < 64'(SNAP_WINDOW)) ticks = target;
        left = 64'(leftover) + ticks;
        while (left >= target && n < UPDATE_LIMIT) begin
          total_acc += target;
          left -= target;
          frame_cnt++;
          outs.push_back('{target[TICK_W-1:0], total_acc, frame_cnt, fps_seen, 1'b0});
          n++;
        end
        // Steps beyond the update limit are dropped.
        if (left >= target) left = left % target;
        leftover = left[LEFT_W-1:0];
      end else begin
        total_acc += ticks;
        leftover = '0;
        frame_cnt++;
        outs.push_back('{ticks[TICK_W-1:0], total_acc, frame_cnt, fps_seen, 1'b0});
        n = 1;
      end
      if (n > 0) begin
        outs[n-1].last = 1'b1;
        frames_in_second++;
      end
      // A full raw-count second has passed: latch the frame rate.
      if (raw_second >= freq_eff) begin
        fps_measured = frames_in_second;
        frames_in_second = '0;
        raw_second = raw_second % freq_eff;
      end
    end
  endtask

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("t=%0t mismatch: %s", $time, what);
  endtask

  // Compares one accepted update beat with the oldest pending update.
  task automatic check_update();
    update_t got;
    update_t want;
    got = '{m_axis_tdata[23:0], m_axis_tdata[87:24], m_axis_tdata[119:88],
            m_axis_tdata[151:120], m_axis_tlast};
    if (pending_updates.size() == 0) begin
      report_mismatch("update beat with no update pending");
    end else begin
      want = pending_updates.pop_front();
      if (got.step_ticks !== want.step_ticks)
        report_mismatch($sformatf("step_ticks %0d, predicted %0d",
                                  got.step_ticks, want.step_ticks));
      if (got.total_ticks !== want.total_ticks)
        report_mismatch($sformatf("total_ticks %0d, predicted %0d",
                                  got.total_ticks, want.total_ticks));
      if (got.frame_number !== want.frame_number)
        report_mismatch($sformatf("frame_number %0d, predicted %0d",
                                  got.frame_number, want.frame_number));
      if (got.frames_per_second !== want.frames_per_second)
        report_mismatch($sformatf("frames_per_second %0d, predicted %0d",
                                  got.frames_per_second, want.frames_per_second));
      if (got.last !== want.last)
        report_mismatch($sformatf("last %0b, predicted %0b", got.last, want.last));
    end
  endtask

  // Receiver: checks accepted beats and stalls in changing patterns.
  rx_mode_e    rx_mode = RX_OPEN;
  int unsigned rx_left = 0;

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) check_update();
    if (rx_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      rx_left = $urandom_range(20, 200);
    end else begin
      rx_left--;
    end
    case (rx_mode)
      RX_OPEN:    m_axis_tready <= 1'b1;
      RX_CHOPPY:  m_axis_tready <= ($urandom_range(0, 2) != 0);
      RX_SPARSE:  m_axis_tready <= (rx_left % 4 == 0);
      default:    m_axis_tready <= (rx_left % 32 < 4);
    endcase
  end

  // Register write; write enable is dropped again before the task returns, which keeps write enable pulses apart.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [FREQ_W-1:0] value);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      CFG_FREQ:    freq_reg = value;
      CFG_MAX_RAW: max_raw_reg = value[RAW_W-1:0];
      CFG_MODE:    fixed_mode_reg = value[0];
      CFG_TARGET:  target_reg = value[TICK_W-1:0];
      default:     ;
    endcase
  endtask

  // Stops sending until every pending update has arrived.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_updates.size() != 0);
  endtask

  // Drained, then enough cycles for a beat that produces nothing to finish.
  task automatic wait_idle();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Sends one timestamp beat, then idles in bursts with random gaps.
  task automatic send_item(input logic op, input logic [TS_W-1:0] stamp,
                           input bit typed, input update_t want);
    update_t     outs[$];
    int unsigned gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= stamp;
    s_axis_tuser <= op;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    advance_timer(op, stamp, outs);
    if (typed) pending_updates.push_back(want);
    else foreach (outs[k]) pending_updates.push_back(outs[k]);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 12);
      case ($urandom_range(0, 3))
        0:       gap = 0;
        1:       gap = $urandom_range(20, 250);
        default: gap = $urandom_range(1, 9);
      endcase
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // Writes every register for one random phase, extremes included.
  task automatic pick_config(input int unsigned phase);
    logic [FREQ_W-1:0] freq;
    logic [FREQ_W-1:0] max_raw;
    logic [FREQ_W-1:0] target;
    case ($urandom_range(0, 5))
      0:       freq = 32'd1000;
      1:       freq = 32'hFFFF_FFFF;
      2:       freq = 32'd10000000;
      3:       freq = (phase == 0) ? 32'd10000000 : 32'd0;
      default: freq = $urandom_range(1000, 100000000);
    endcase
    case ($urandom_range(0, 3))
      0:       max_raw = 32'd1;
      1:       max_raw = 32'd429496729;
      2:       max_raw = $urandom_range(1, 429496729);
      default: max_raw = (freq / 10 > 32'd429496729) ? 32'd429496729 :
                         (freq < 10) ? 32'd1 : freq / 10;
    endcase
    case ($urandom_range(0, 3))
      0:       target = 32'd20000;
      1:       target = 32'd10000000;
      2:       target = 32'd166666;
      default: target = $urandom_range(20000, 10000000);
    endcase
    write_reg(CFG_FREQ, freq);
    write_reg(CFG_MAX_RAW, max_raw);
    write_reg(CFG_MODE, (phase % 2 == 0) ? 32'd1 : 32'd0);
    write_reg(CFG_TARGET, target);
  endtask

  // Watchdog.
  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : stimulus
    logic [TS_W-1:0] cursor;
    logic [TS_W-1:0] freq_eff;
    logic [TS_W-1:0] tgt_eff;
    logic [TS_W-1:0] frame_raw;
    logic [TS_W-1:0] span;
    logic            op;
    int unsigned     pick;

    plan = '{
      // Default config: variable mode, clamp at 1e6 raw counts.
      '{ROW_TICK, '0, 1'b0, 64'd10000000, 1'b1,
        '{24'd1000000, 64'd1000000, 32'd1, 32'd0, 1'b1}},
      '{ROW_TICK, '0, 1'b0, 64'd10000500, 1'b1,
        '{24'd500, 64'd1000500, 32'd2, 32'd1, 1'b1}},
      // Timestamp going backwards, then the largest timestamp.
      '{ROW_TICK, '0, 1'b0, 64'd0, 1'b1,
        '{24'd1000000, 64'd2000500, 32'd3, 32'd1, 1'b1}},
      '{ROW_TICK, '0, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
        '{24'd1000000, 64'd3000500, 32'd4, 32'd2, 1'b1}},
      '{ROW_REBASE, '0, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, NO_WANT},
      // Wrap by one count, then a zero delta.
      '{ROW_TICK, '0, 1'b0, 64'd0, 1'b1,
        '{24'd1, 64'd3000501, 32'd5, 32'd0, 1'b1}},
      '{ROW_TICK, '0, 1'b0, 64'd0, 1'b1,
        '{24'd0, 64'd3000501, 32'd6, 32'd0, 1'b1}},
      '{ROW_CFG, CFG_MODE, 1'b0, 64'd1, 1'b0, NO_WANT},
      // Fixed mode: snapped frame, short frame, multi-step frames.
      '{ROW_TICK, '0, 1'b1, 64'd168666, 1'b1,
        '{24'd166666, 64'd3167167, 32'd7, 32'd0, 1'b1}},
      '{ROW_TICK, '0, 1'b1, 64'd100000, 1'b0, NO_WANT},
      '{ROW_TICK, '0, 1'b1, 64'd300000, 1'b0, NO_WANT},
      '{ROW_TICK, '0, 1'b1, 64'd1000000, 1'b0, NO_WANT},
      // Just inside and just outside the snap window.
      '{ROW_TICK, '0, 1'b1, 64'd169165, 1'b0, NO_WANT},
      '{ROW_TICK, '0, 1'b1, 64'd164166, 1'b0, NO_WANT},
      // Zero target behaves as one tick: update limit is hit.
      '{ROW_CFG, CFG_TARGET, 1'b0, 64'd0, 1'b0, NO_WANT},
      '{ROW_TICK, '0, 1'b1, 64'd1000000, 1'b0, NO_WANT},
      // Zero frequency behaves as one count per second.
      '{ROW_CFG, CFG_FREQ, 1'b0, 64'd0, 1'b0, NO_WANT},
      '{ROW_TICK, '0, 1'b1, 64'd1, 1'b0, NO_WANT},
      // Slowest counter, widest clamp, longest step: tick saturation.
      '{ROW_CFG, CFG_TARGET, 1'b0, 64'd10000000, 1'b0, NO_WANT},
      '{ROW_CFG, CFG_FREQ, 1'b0, 64'd1000, 1'b0, NO_WANT},
      '{ROW_CFG, CFG_MAX_RAW, 1'b0, 64'd429496729, 1'b0, NO_WANT},
      '{ROW_TICK, '0, 1'b1, 64'd429496729, 1'b0, NO_WANT},
      '{ROW_TICK, '0, 1'b1, 64'd429496729, 1'b0, NO_WANT},
      '{ROW_CFG, CFG_MAX_RAW, 1'b0, 64'd1, 1'b0, NO_WANT},
      '{ROW_TICK, '0, 1'b1, 64'd5, 1'b0, NO_WANT},
      '{ROW_CFG, CFG_MODE, 1'b0, 64'd0, 1'b0, NO_WANT},
      '{ROW_TICK, '0, 1'b1, 64'd7, 1'b0, NO_WANT},
      // Fastest counter: a one-count delta rounds to zero ticks.
      '{ROW_CFG, CFG_FREQ, 1'b0, 64'hFFFF_FFFF, 1'b0, NO_WANT},
      '{ROW_TICK, '0, 1'b1, 64'd1, 1'b0, NO_WANT},
      '{ROW_REBASE, '0, 1'b0, 64'h8000_0000_0000_0000, 1'b0, NO_WANT},
      '{ROW_TICK, '0, 1'b1, 64'd1, 1'b0, NO_WANT},
      '{ROW_TICK, '0, 1'b1, 64'h5555_5555_5555_5555, 1'b0, NO_WANT}
    };

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows.
    cursor = '0;
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        if (i > 0 && plan[i-1].kind != ROW_CFG) wait_idle();
        write_reg(plan[i].idx, plan[i].value[FREQ_W-1:0]);
      end else begin
        cursor = plan[i].rel ? cursor + plan[i].value : plan[i].value;
        send_item((plan[i].kind == ROW_REBASE) ? OP_REBASE : OP_TICK, cursor,
                  plan[i].typed, plan[i].want);
      end
    end

    // Random phases: mostly frame-length deltas with jitter around the
    // snap window, plus odd deltas, wild timestamps and re-bases.
    for (int unsigned p = 0; p < RAND_PHASES; p++) begin
      wait_idle();
      pick_config(p);
      freq_eff = (freq_reg == '0) ? 64'd1 : 64'(freq_reg);
      tgt_eff = (target_reg == '0) ? 64'd1 : 64'(target_reg);
      frame_raw = freq_eff * tgt_eff / 64'(TICK_RATE);
      span = freq_eff * 64'd3000 / 64'(TICK_RATE);
      for (int unsigned k = 0; k < ITEMS_PER_PHASE; k++) begin
        if (k == ITEMS_PER_PHASE / 2) wait_drained();
        pick = $urandom_range(0, 99);
        op = OP_TICK;
        if (pick < 70) begin
          cursor = cursor + frame_raw + 64'($urandom_range(0, 2 * span[31:0])) - span;
        end else if (pick < 80) begin
          cursor = cursor + 64'($urandom_range(0, 2 * 32'(max_raw_reg)));
        end else if (pick < 87) begin
          cursor = {$urandom, $urandom};
        end else if (pick < 93) begin
          op = OP_REBASE;
          if ($urandom_range(0, 1) == 0) cursor = {$urandom, $urandom};
        end else begin
          cursor = cursor - 64'($urandom_range(1, 1000000));
        end
        send_item(op, cursor, 1'b0, NO_WANT);
      end
    end

    // Drain and let any stray beat show up.
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
